// ===== src/rmq_pkg.sv =====
// Shared types and constants of the rotation matrix to quaternion block.
`timescale 1ns / 1ps
package rmq_pkg;

   localparam int FIELD_W = 18;
   localparam int NUM_W   = 19;
   localparam int QUO_W   = 19;
   localparam int SQ_W    = 35;
   localparam int SUMSQ_W = 37;

   typedef logic signed [FIELD_W-1:0] fix_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef logic [1:0]                branch_type;

   localparam fix_type FIELD_MAX = 18'sd131071;
   localparam fix_type FIELD_MIN = -18'sd131072;
   localparam logic [QUO_W-1:0] MAG_POS_MAX = 19'd131071;
   localparam logic [QUO_W-1:0] MAG_NEG_MAX = 19'd131072;

   localparam branch_type BR_W = 2'd0;
   localparam branch_type BR_X = 2'd1;
   localparam branch_type BR_Y = 2'd2;
   localparam branch_type BR_Z = 2'd3;

endpackage

// ===== src/rmq_delay.sv =====
// Fixed-length register delay line for payload that rides beside a pipelined unit.
`timescale 1ns / 1ps
module rmq_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];
   logic [WIDTH-1:0] tap_in [0:DEPTH-1];

   always_comb begin
      tap_in[0] = din;
      for (int k = 1; k < DEPTH; k++) begin
         tap_in[k] = tap_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

// ===== src/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt #(
   parameter int IN_W = 36,
   parameter int RT_W = (IN_W + 1) / 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [IN_W-1:0] in_value,
   output logic            out_valid,
   output logic [RT_W-1:0] out_root
);
   localparam int TW = 2 * RT_W + 2;

   logic            valid_ff [0:RT_W];
   logic            valid_in [0:RT_W];
   logic [IN_W-1:0] rem_ff   [0:RT_W];
   logic [IN_W-1:0] rem_in   [0:RT_W];
   logic [RT_W-1:0] res_ff   [0:RT_W];
   logic [RT_W-1:0] res_in   [0:RT_W];
   logic [TW-1:0]   trial    [0:RT_W-1];

   always_comb begin
      valid_in[0] = in_valid;
      rem_in[0]   = in_value;
      res_in[0]   = '0;
      for (int k = 0; k < RT_W; k++) begin
         trial[k] = (TW'(res_ff[k]) << (RT_W - k)) + (TW'(1) << (2 * (RT_W - 1 - k)));
         valid_in[k+1] = valid_ff[k];
         if (TW'(rem_ff[k]) >= trial[k]) begin
            rem_in[k+1] = rem_ff[k] - IN_W'(trial[k]);
            res_in[k+1] = res_ff[k] | (RT_W'(1) << (RT_W - 1 - k));
         end else begin
            rem_in[k+1] = rem_ff[k];
            res_in[k+1] = res_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= RT_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign out_valid = valid_ff[RT_W];
   assign out_root  = res_ff[RT_W];
endmodule

// ===== src/rmq_div.sv =====
// Pipelined restoring divider: saturated (num << SHIFT) / den, truncated toward zero.
`timescale 1ns / 1ps
module rmq_div #(
   parameter int NUM_BITS = 19,
   parameter int DEN_BITS = 19,
   parameter int SHIFT    = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0]        in_den,
   output logic                       out_valid,
   output rmq_pkg::fix_type           out_quo
);
   import rmq_pkg::*;

   localparam int MW = NUM_BITS + SHIFT;
   localparam int CW = MW + DEN_BITS + QUO_W;

   logic                valid_ff [0:QUO_W];
   logic                valid_in [0:QUO_W];
   logic [MW-1:0]       rem_ff   [0:QUO_W];
   logic [MW-1:0]       rem_in   [0:QUO_W];
   logic [QUO_W-1:0]    quo_ff   [0:QUO_W];
   logic [QUO_W-1:0]    quo_in   [0:QUO_W];
   logic [DEN_BITS-1:0] den_ff   [0:QUO_W];
   logic [DEN_BITS-1:0] den_in   [0:QUO_W];
   logic                neg_ff   [0:QUO_W];
   logic                neg_in   [0:QUO_W];
   logic                ovf_ff   [0:QUO_W];
   logic                ovf_in   [0:QUO_W];
   logic [CW-1:0]       dsh      [0:QUO_W-1];
   logic [NUM_BITS-1:0] num_abs;
   logic                out_valid_ff;
   fix_type             out_quo_ff;
   fix_type             out_quo_in;

   always_comb begin
      num_abs     = in_num[NUM_BITS-1] ? NUM_BITS'(-in_num) : NUM_BITS'(in_num);
      valid_in[0] = in_valid;
      rem_in[0]   = MW'(num_abs) << SHIFT;
      quo_in[0]   = '0;
      den_in[0]   = in_den;
      neg_in[0]   = in_num[NUM_BITS-1];
      ovf_in[0]   = CW'(MW'(num_abs) << SHIFT) >= (CW'(in_den) << QUO_W);
      for (int k = 0; k < QUO_W; k++) begin
         dsh[k]        = CW'(den_ff[k]) << (QUO_W - 1 - k);
         valid_in[k+1] = valid_ff[k];
         den_in[k+1]   = den_ff[k];
         neg_in[k+1]   = neg_ff[k];
         ovf_in[k+1]   = ovf_ff[k];
         if (CW'(rem_ff[k]) >= dsh[k]) begin
            rem_in[k+1] = rem_ff[k] - MW'(dsh[k]);
            quo_in[k+1] = quo_ff[k] | (QUO_W'(1) << (QUO_W - 1 - k));
         end else begin
            rem_in[k+1] = rem_ff[k];
            quo_in[k+1] = quo_ff[k];
         end
      end
      if (den_ff[QUO_W] == '0) begin
         out_quo_in = '0;
      end else if (neg_ff[QUO_W]) begin
         if (ovf_ff[QUO_W] || quo_ff[QUO_W] > MAG_NEG_MAX) begin
            out_quo_in = FIELD_MIN;
         end else begin
            out_quo_in = fix_type'(-quo_ff[QUO_W]);
         end
      end else begin
         if (ovf_ff[QUO_W] || quo_ff[QUO_W] > MAG_POS_MAX) begin
            out_quo_in = FIELD_MAX;
         end else begin
            out_quo_in = fix_type'(quo_ff[QUO_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[QUO_W];
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      ovf_ff     <= ovf_in;
      out_quo_ff <= out_quo_in;
   end

   assign out_valid = out_valid_ff;
   assign out_quo   = out_quo_ff;
endmodule

// ===== src/rotation_matrix_to_quaternion.sv =====
// Top level: Shepperd rotation matrix to unit quaternion conversion pipeline.
// Throughput: one matrix per cycle, busy stays low; the receiver cannot stall.
// Depth is set by the two bit-per-stage square roots and the two banks of dividers.
// Reset clears all valid bits and sets min_norm to 66; no clearing pass.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rmq_pkg::fix_type req_r00,
   input  rmq_pkg::fix_type req_r01,
   input  rmq_pkg::fix_type req_r02,
   input  rmq_pkg::fix_type req_r10,
   input  rmq_pkg::fix_type req_r11,
   input  rmq_pkg::fix_type req_r12,
   input  rmq_pkg::fix_type req_r20,
   input  rmq_pkg::fix_type req_r21,
   input  rmq_pkg::fix_type req_r22,
   output logic             rsp_valid,
   output rmq_pkg::fix_type rsp_quat_x,
   output rmq_pkg::fix_type rsp_quat_y,
   output rmq_pkg::fix_type rsp_quat_z,
   output rmq_pkg::fix_type rsp_quat_w,
   output logic [1:0]       rsp_branch_used,
   output logic             rsp_identity_fallback,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import rmq_pkg::*;

   localparam int RADW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 1;
   localparam int EW    = RADW + 1;
   localparam int NW1   = RADW + FRAC_BITS;
   localparam int RW1   = (NW1 + 1) / 2;
   localparam int RW2   = (SUMSQ_W + 1) / 2;
   localparam int DIV_LAT = QUO_W + 2;
   localparam fix_type IDENT_W = (FRAC_BITS >= 17) ? FIELD_MAX : fix_type'(1 << FRAC_BITS);
   localparam logic [16:0] MIN_NORM_RESET = 17'd66;

   // configuration
   logic [16:0] min_norm_ff;
   logic        csr_write;

   assign csr_write = psel && penable && pwrite && !paddr[2];
   assign pready    = 1'b1;
   assign prdata    = !paddr[2] ? {15'b0, min_norm_ff} : 32'b0;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_ff <= MIN_NORM_RESET;
      end else if (csr_write) begin
         min_norm_ff <= pwdata[16:0];
      end
   end

   // stage A: input capture
   logic    valid_a_ff;
   fix_type m_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start;
      end
      m_ff[0] <= req_r00;
      m_ff[1] <= req_r01;
      m_ff[2] <= req_r02;
      m_ff[3] <= req_r10;
      m_ff[4] <= req_r11;
      m_ff[5] <= req_r12;
      m_ff[6] <= req_r20;
      m_ff[7] <= req_r21;
      m_ff[8] <= req_r22;
   end

   // stage B: branch select, radicand, numerators
   logic signed [EW-1:0] d00, d11, d22, trace, rad, one_e;
   logic [RADW-1:0]      rad_b_in, rad_b_ff;
   branch_type           br_b_in, br_b_ff;
   num_type              dif_x, dif_y, dif_z, sum_xy, sum_xz, sum_yz;
   num_type              num_b_in [0:2];
   num_type              num_b_ff [0:2];
   logic                 valid_b_ff;

   always_comb begin
      d00   = EW'(m_ff[0]);
      d11   = EW'(m_ff[4]);
      d22   = EW'(m_ff[8]);
      one_e = EW'(1) << FRAC_BITS;
      trace = d00 + d11 + d22;
      dif_x  = num_type'(m_ff[7]) - num_type'(m_ff[5]);
      dif_y  = num_type'(m_ff[2]) - num_type'(m_ff[6]);
      dif_z  = num_type'(m_ff[3]) - num_type'(m_ff[1]);
      sum_xy = num_type'(m_ff[1]) + num_type'(m_ff[3]);
      sum_xz = num_type'(m_ff[2]) + num_type'(m_ff[6]);
      sum_yz = num_type'(m_ff[5]) + num_type'(m_ff[7]);
      if (trace > 0) begin
         br_b_in     = BR_W;
         rad         = trace + one_e;
         num_b_in[0] = dif_x;
         num_b_in[1] = dif_y;
         num_b_in[2] = dif_z;
      end else if (d00 > d11 && d00 > d22) begin
         br_b_in     = BR_X;
         rad         = one_e + d00 - d11 - d22;
         num_b_in[0] = dif_x;
         num_b_in[1] = sum_xy;
         num_b_in[2] = sum_xz;
      end else if (d11 > d22) begin
         br_b_in     = BR_Y;
         rad         = one_e + d11 - d00 - d22;
         num_b_in[0] = dif_y;
         num_b_in[1] = sum_xy;
         num_b_in[2] = sum_yz;
      end else begin
         br_b_in     = BR_Z;
         rad         = one_e + d22 - d00 - d11;
         num_b_in[0] = dif_z;
         num_b_in[1] = sum_xz;
         num_b_in[2] = sum_yz;
      end
      rad_b_in = rad[EW-1] ? '0 : rad[RADW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      rad_b_ff <= rad_b_in;
      br_b_ff  <= br_b_in;
      num_b_ff <= num_b_in;
   end

   // first square root
   logic                    sq1_valid;
   logic [RW1-1:0]          sq1_root;
   logic [3*NUM_W+1:0]      side1;

   rmq_sqrt #(.IN_W(NW1), .RT_W(RW1)) u_sqrt_main (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_b_ff),
      .in_value  ({rad_b_ff, {FRAC_BITS{1'b0}}}),
      .out_valid (sq1_valid),
      .out_root  (sq1_root)
   );

   rmq_delay #(.WIDTH(3*NUM_W+2), .DEPTH(RW1+1)) u_dly_num (
      .clock (clock),
      .din   ({br_b_ff, num_b_ff[0], num_b_ff[1], num_b_ff[2]}),
      .dout  (side1)
   );

   // stage C: scale, main component
   logic           valid_c_ff;
   logic [RW1:0]   s_c_ff;
   fix_type        main_c_in, main_c_ff;
   branch_type     br_c_ff;
   num_type        num_c_ff [0:2];
   logic [RW1-1:0] root_half;

   always_comb begin
      root_half = sq1_root >> 1;
      if (32'(root_half) > 32'(FIELD_MAX)) begin
         main_c_in = FIELD_MAX;
      end else begin
         main_c_in = fix_type'(root_half);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= sq1_valid;
      end
      s_c_ff      <= {sq1_root, 1'b0};
      main_c_ff   <= main_c_in;
      br_c_ff     <= side1[3*NUM_W+1:3*NUM_W];
      num_c_ff[0] <= side1[3*NUM_W-1:2*NUM_W];
      num_c_ff[1] <= side1[2*NUM_W-1:NUM_W];
      num_c_ff[2] <= side1[NUM_W-1:0];
   end

   // first dividers
   logic           dv1_valid [0:2];
   fix_type        dv1_quo   [0:2];
   logic [FIELD_W+1:0] side2;

   for (genvar g = 0; g < 3; g++) begin : g_div_off
      rmq_div #(.NUM_BITS(NUM_W), .DEN_BITS(RW1+1), .SHIFT(FRAC_BITS)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_c_ff),
         .in_num    (num_c_ff[g]),
         .in_den    (s_c_ff),
         .out_valid (dv1_valid[g]),
         .out_quo   (dv1_quo[g])
      );
   end

   rmq_delay #(.WIDTH(FIELD_W+2), .DEPTH(DIV_LAT)) u_dly_main (
      .clock (clock),
      .din   ({br_c_ff, main_c_ff}),
      .dout  (side2)
   );

   // stage D: assemble unnormalized quaternion
   logic       valid_d_ff;
   branch_type br_d_ff;
   fix_type    q_d_in [0:3];
   fix_type    q_d_ff [0:3];
   fix_type    main_d;

   always_comb begin
      main_d = side2[FIELD_W-1:0];
      case (side2[FIELD_W+1:FIELD_W])
         BR_W: begin
            q_d_in[0] = dv1_quo[0];
            q_d_in[1] = dv1_quo[1];
            q_d_in[2] = dv1_quo[2];
            q_d_in[3] = main_d;
         end
         BR_X: begin
            q_d_in[0] = main_d;
            q_d_in[1] = dv1_quo[1];
            q_d_in[2] = dv1_quo[2];
            q_d_in[3] = dv1_quo[0];
         end
         BR_Y: begin
            q_d_in[0] = dv1_quo[1];
            q_d_in[1] = main_d;
            q_d_in[2] = dv1_quo[2];
            q_d_in[3] = dv1_quo[0];
         end
         default: begin
            q_d_in[0] = dv1_quo[1];
            q_d_in[1] = dv1_quo[2];
            q_d_in[2] = main_d;
            q_d_in[3] = dv1_quo[0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else begin
         valid_d_ff <= dv1_valid[0];
      end
      q_d_ff  <= q_d_in;
      br_d_ff <= side2[FIELD_W+1:FIELD_W];
   end

   // stage E: squares
   logic                      valid_e_ff;
   branch_type                br_e_ff;
   fix_type                   q_e_ff  [0:3];
   logic [SQ_W-1:0]           sq_e_ff [0:3];
   logic signed [2*FIELD_W-1:0] prod  [0:3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod[k] = q_d_ff[k] * q_d_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_e_ff <= 1'b0;
      end else begin
         valid_e_ff <= valid_d_ff;
      end
      for (int k = 0; k < 4; k++) begin
         sq_e_ff[k] <= prod[k][SQ_W-1:0];
      end
      q_e_ff  <= q_d_ff;
      br_e_ff <= br_d_ff;
   end

   // stage F: sum of squares
   logic               valid_f_ff;
   branch_type         br_f_ff;
   fix_type            q_f_ff [0:3];
   logic [SUMSQ_W-1:0] sumsq_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f_ff <= 1'b0;
      end else begin
         valid_f_ff <= valid_e_ff;
      end
      sumsq_f_ff <= SUMSQ_W'(sq_e_ff[0]) + SUMSQ_W'(sq_e_ff[1])
                  + SUMSQ_W'(sq_e_ff[2]) + SUMSQ_W'(sq_e_ff[3]);
      q_f_ff  <= q_e_ff;
      br_f_ff <= br_e_ff;
   end

   // norm
   logic                   sq2_valid;
   logic [RW2-1:0]         norm;
   logic [4*FIELD_W+1:0]   side3;
   fix_type                q_n [0:3];
   logic                   ident_n;
   logic [2:0]             side4;

   rmq_sqrt #(.IN_W(SUMSQ_W), .RT_W(RW2)) u_sqrt_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_f_ff),
      .in_value  (sumsq_f_ff),
      .out_valid (sq2_valid),
      .out_root  (norm)
   );

   rmq_delay #(.WIDTH(4*FIELD_W+2), .DEPTH(RW2+1)) u_dly_quat (
      .clock (clock),
      .din   ({br_f_ff, q_f_ff[0], q_f_ff[1], q_f_ff[2], q_f_ff[3]}),
      .dout  (side3)
   );

   assign q_n[0]  = side3[4*FIELD_W-1:3*FIELD_W];
   assign q_n[1]  = side3[3*FIELD_W-1:2*FIELD_W];
   assign q_n[2]  = side3[2*FIELD_W-1:FIELD_W];
   assign q_n[3]  = side3[FIELD_W-1:0];
   assign ident_n = (norm == '0) || (norm < RW2'(min_norm_ff));

   // normalizing dividers
   logic    dv2_valid [0:3];
   fix_type dv2_quo   [0:3];

   for (genvar g = 0; g < 4; g++) begin : g_div_norm
      rmq_div #(.NUM_BITS(FIELD_W), .DEN_BITS(RW2), .SHIFT(FRAC_BITS)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq2_valid),
         .in_num    (q_n[g]),
         .in_den    (norm),
         .out_valid (dv2_valid[g]),
         .out_quo   (dv2_quo[g])
      );
   end

   rmq_delay #(.WIDTH(3), .DEPTH(DIV_LAT)) u_dly_flag (
      .clock (clock),
      .din   ({side3[4*FIELD_W+1:4*FIELD_W], ident_n}),
      .dout  (side4)
   );

   // output register
   logic       rsp_valid_ff;
   fix_type    rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_w_ff;
   branch_type rsp_br_ff;
   logic       rsp_ident_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv2_valid[0];
      end
      rsp_br_ff    <= side4[2:1];
      rsp_ident_ff <= side4[0];
      if (side4[0]) begin
         rsp_x_ff <= '0;
         rsp_y_ff <= '0;
         rsp_z_ff <= '0;
         rsp_w_ff <= IDENT_W;
      end else begin
         rsp_x_ff <= dv2_quo[0];
         rsp_y_ff <= dv2_quo[1];
         rsp_z_ff <= dv2_quo[2];
         rsp_w_ff <= dv2_quo[3];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_quat_x            = rsp_x_ff;
   assign rsp_quat_y            = rsp_y_ff;
   assign rsp_quat_z            = rsp_z_ff;
   assign rsp_quat_w            = rsp_w_ff;
   assign rsp_branch_used       = rsp_br_ff;
   assign rsp_identity_fallback = rsp_ident_ff;
endmodule

// ===== src/rmq_checker.sv =====
// Port-level assertions for the rotation matrix to quaternion block, bound to the top level.
`timescale 1ns / 1ps
module rmq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input rmq_pkg::fix_type rsp_quat_x,
   input rmq_pkg::fix_type rsp_quat_y,
   input rmq_pkg::fix_type rsp_quat_z,
   input rmq_pkg::fix_type rsp_quat_w,
   input logic [1:0]       rsp_branch_used,
   input logic             rsp_identity_fallback,
   input logic             psel,
   input logic             penable,
   input logic             pwrite,
   input logic [2:0]       paddr,
   input logic [31:0]      pwdata,
   input logic [31:0]      prdata
);
   import rmq_pkg::*;

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transfer right after reset");

   a_identity_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_identity_fallback |->
         rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0)
      else $error("identity result with nonzero vector part");

   a_w_branch_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_identity_fallback && rsp_branch_used == BR_W |->
         !rsp_quat_w[FIELD_W-1])
      else $error("w branch gave negative w");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2]) |->
         prdata == {15'b0, $past(pwdata[16:0])})
      else $error("min_norm readback mismatch");
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

// ===== tb/sv/tb_rotation_matrix_to_quaternion.sv =====
// Testbench for the rotation matrix to quaternion converter: predicted results vs. DUT output.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion;
   import rmq_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 88;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] ADDR_MIN_NORM = 3'd0;

   typedef struct {
      fix_type    qx, qy, qz, qw;
      branch_type branch;
      logic       ident;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   fix_type req_r00 = '0, req_r01 = '0, req_r02 = '0;
   fix_type req_r10 = '0, req_r11 = '0, req_r12 = '0;
   fix_type req_r20 = '0, req_r21 = '0, req_r22 = '0;
   logic rsp_valid;
   fix_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic [1:0] rsp_branch_used;
   logic rsp_identity_fallback;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   quat_type expected_quats[$];
   longint min_norm_model;
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   bit timed_out = 1'b0;

   rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint isqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint clip18(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic longint frac_div(longint num, longint den);
      if (den == 0) return 0;
      return clip18((num * (longint'(1) << FRAC)) / den);
   endfunction

   function automatic quat_type shepperd(fix_type m[9]);
      longint a[9];
      longint one, tr, rad, r, s, mainc, sumsq, norm;
      longint q[4];
      quat_type res;
      one = longint'(1) << FRAC;
      foreach (a[i]) a[i] = longint'(m[i]);
      tr = a[0] + a[4] + a[8];
      if (tr > 0) begin
         res.branch = BR_W;
         rad = tr + one;
      end else if (a[0] > a[4] && a[0] > a[8]) begin
         res.branch = BR_X;
         rad = one + a[0] - a[4] - a[8];
      end else if (a[4] > a[8]) begin
         res.branch = BR_Y;
         rad = one + a[4] - a[0] - a[8];
      end else begin
         res.branch = BR_Z;
         rad = one + a[8] - a[0] - a[4];
      end
      if (rad < 0) rad = 0;
      r = isqrt(rad << FRAC);
      s = 2 * r;
      mainc = clip18(r >>> 1);
      case (res.branch)
         BR_W: begin
            q[3] = mainc;
            q[0] = frac_div(a[7] - a[5], s);
            q[1] = frac_div(a[2] - a[6], s);
            q[2] = frac_div(a[3] - a[1], s);
         end
         BR_X: begin
            q[3] = frac_div(a[7] - a[5], s);
            q[0] = mainc;
            q[1] = frac_div(a[1] + a[3], s);
            q[2] = frac_div(a[2] + a[6], s);
         end
         BR_Y: begin
            q[3] = frac_div(a[2] - a[6], s);
            q[0] = frac_div(a[1] + a[3], s);
            q[1] = mainc;
            q[2] = frac_div(a[5] + a[7], s);
         end
         default: begin
            q[3] = frac_div(a[3] - a[1], s);
            q[0] = frac_div(a[2] + a[6], s);
            q[1] = frac_div(a[5] + a[7], s);
            q[2] = mainc;
         end
      endcase
      sumsq = 0;
      foreach (q[i]) sumsq += q[i] * q[i];
      norm = isqrt(sumsq);
      res.ident = (norm == 0) || (norm < min_norm_model);
      if (res.ident) begin
         foreach (q[i]) q[i] = 0;
         q[3] = clip18(one);
      end else begin
         foreach (q[i]) q[i] = clip18((q[i] * one) / norm);
      end
      res.qx = fix_type'(q[0]);
      res.qy = fix_type'(q[1]);
      res.qz = fix_type'(q[2]);
      res.qw = fix_type'(q[3]);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Result checker
   always @(posedge clock) begin
      quat_type exp_q;
      if (!reset && rsp_valid) begin
         if (expected_quats.size() == 0) begin
            report_mismatch("unexpected transfer", 0, 0);
         end else begin
            exp_q = expected_quats[0];
            expected_quats.delete(0);
            if (rsp_quat_x !== exp_q.qx) report_mismatch("quat_x", rsp_quat_x, exp_q.qx);
            if (rsp_quat_y !== exp_q.qy) report_mismatch("quat_y", rsp_quat_y, exp_q.qy);
            if (rsp_quat_z !== exp_q.qz) report_mismatch("quat_z", rsp_quat_z, exp_q.qz);
            if (rsp_quat_w !== exp_q.qw) report_mismatch("quat_w", rsp_quat_w, exp_q.qw);
            if (rsp_branch_used !== exp_q.branch)
               report_mismatch("branch_used", rsp_branch_used, exp_q.branch);
            if (rsp_identity_fallback !== exp_q.ident)
               report_mismatch("identity_fallback", rsp_identity_fallback, exp_q.ident);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb_rotation_matrix_to_quaternion NOT OK");
         $finish;
      end
   end

   task automatic send_matrix(fix_type m[9]);
      if ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_r00 <= m[0]; req_r01 <= m[1]; req_r02 <= m[2];
      req_r10 <= m[3]; req_r11 <= m[4]; req_r12 <= m[5];
      req_r20 <= m[6]; req_r21 <= m[7]; req_r22 <= m[8];
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_quats = {expected_quats, shepperd(m)};
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_MIN_NORM) min_norm_model = data & 32'h1FFFF;
   endtask

   function automatic fix_type rand_fix();
      return fix_type'($urandom);
   endfunction

   // Near-rotation: matrix with noise, random signs and permutation
   function automatic void rand_rotation(ref fix_type m[9]);
      int unsigned c, sn, noise;
      int p;
      c = $urandom_range(65536);
      sn = $urandom_range(65536);
      noise = $urandom_range(3) == 0 ? 4000 : 40;
      foreach (m[i]) m[i] = fix_type'($signed($urandom_range(2 * noise)) - noise);
      p = $urandom_range(2);
      m[p * 4] += fix_type'(65536);
      m[((p + 1) % 3) * 4] += $urandom_range(1) ? fix_type'(c) : -fix_type'(c);
      m[((p + 2) % 3) * 4] += $urandom_range(1) ? fix_type'(c) : -fix_type'(c);
      m[((p + 1) % 3) * 3 + (p + 2) % 3] += fix_type'(sn);
      m[((p + 2) % 3) * 3 + (p + 1) % 3] -= fix_type'(sn);
   endfunction

   task automatic test_directed();
      fix_type m[9];
      fix_type ext[4] = '{FIELD_MAX, FIELD_MIN, 18'sd0, 18'sd65536};
      foreach (m[i]) m[i] = '0;
      m[0] = 18'sd65536; m[4] = 18'sd65536; m[8] = 18'sd65536;
      send_matrix(m);
      m[0] = 18'sd65536; m[4] = -18'sd65536; m[8] = -18'sd65536;
      send_matrix(m);
      m[0] = -18'sd65536; m[4] = 18'sd65536; m[8] = -18'sd65536;
      send_matrix(m);
      m[0] = -18'sd65536; m[4] = -18'sd65536; m[8] = 18'sd65536;
      send_matrix(m);
      foreach (m[i]) m[i] = '0;
      send_matrix(m);
      foreach (m[i]) m[i] = FIELD_MAX;
      send_matrix(m);
      foreach (m[i]) m[i] = FIELD_MIN;
      send_matrix(m);
      foreach (m[i]) m[i] = '1;
      m[0] = -18'sd65536; m[4] = -18'sd65536; m[8] = -18'sd65536;
      send_matrix(m);
      m[0] = FIELD_MIN; m[4] = FIELD_MAX; m[8] = FIELD_MAX;
      send_matrix(m);
      m[0] = -18'sd100; m[4] = -18'sd100; m[8] = -18'sd200;
      send_matrix(m);
      for (int k = 0; k < 12; k++) begin
         foreach (m[i]) m[i] = ext[$urandom_range(3)];
         send_matrix(m);
      end
      drain();
   endtask

   task automatic test_min_norm_settings();
      logic [31:0] settings[4] = '{32'd0, 32'h1FFFF, 32'd70000, 32'd65536};
      fix_type m[9];
      foreach (settings[k]) begin
         csr_write(ADDR_MIN_NORM, settings[k]);
         for (int n = 0; n < 30; n++) begin
            rand_rotation(m);
            send_matrix(m);
         end
         drain();
      end
      csr_write(ADDR_MIN_NORM, 32'd66);
   endtask

   task automatic test_random_phase(int pct, int count);
      fix_type m[9];
      send_idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 7) rand_rotation(m);
         else foreach (m[i]) m[i] = rand_fix();
         send_matrix(m);
         if (n == count / 2 && pct == 0) drain();
      end
      drain();
      send_idle_pct = 0;
   endtask

   initial begin
      min_norm_model = 66;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_min_norm_settings();
      test_random_phase(0, 400);
      test_random_phase(75, 350);
      test_random_phase(11, 350);
      test_random_phase(0, 250);
      drain();
      if (mismatches == 0) $display("tb_rotation_matrix_to_quaternion OK");
      else $display("tb_rotation_matrix_to_quaternion NOT OK");
      $finish;
   end
endmodule
